// ===== hdl/mps_pkg.sv =====
// ----------------------------------------------------------------------------
// mps_pkg: shared codes and types of the motor power sequencer
// Mode and event codes, and the word that the dispatch logic hands back.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

  localparam int ModeW  = 4;
  localparam int EventW = 5;

  localparam logic [ModeW-1:0] MODE_OFF      = 4'd0;
  localparam logic [ModeW-1:0] MODE_NOMOTOR  = 4'd1;
  localparam logic [ModeW-1:0] MODE_STARTING = 4'd2;
  localparam logic [ModeW-1:0] MODE_POWERED  = 4'd3;
  localparam logic [ModeW-1:0] MODE_IDLE     = 4'd4;
  localparam logic [ModeW-1:0] MODE_PREON    = 4'd5;
  localparam logic [ModeW-1:0] MODE_PREOFF   = 4'd6;
  localparam logic [ModeW-1:0] MODE_ARMED    = 4'd7;
  localparam logic [ModeW-1:0] MODE_POWON    = 4'd8;
  localparam logic [ModeW-1:0] MODE_POWOFF   = 4'd9;
  localparam logic [ModeW-1:0] MODE_ACTIVE   = 4'd10;
  localparam logic [ModeW-1:0] MODE_NONE     = 4'd15;

  localparam logic [EventW-1:0] EV_START       = 5'd0;
  localparam logic [EventW-1:0] EV_STOP        = 5'd1;
  localparam logic [EventW-1:0] EV_PRESENT     = 5'd2;
  localparam logic [EventW-1:0] EV_NOT_PRESENT = 5'd3;
  localparam logic [EventW-1:0] EV_BRINGUP_TO  = 5'd4;
  localparam logic [EventW-1:0] EV_STATUS_OK   = 5'd5;
  localparam logic [EventW-1:0] EV_STATUS_ERR  = 5'd6;
  localparam logic [EventW-1:0] EV_STATUS_EE   = 5'd7;
  localparam logic [EventW-1:0] EV_STATUS_DE   = 5'd8;
  localparam logic [EventW-1:0] EV_STATUS_TEMP = 5'd9;
  localparam logic [EventW-1:0] EV_STATUS_ED   = 5'd10;
  localparam logic [EventW-1:0] EV_STATUS_DD   = 5'd11;
  localparam logic [EventW-1:0] EV_TEMP_INQ    = 5'd12;
  localparam logic [EventW-1:0] EV_PARAM_INQ   = 5'd13;
  localparam logic [EventW-1:0] EV_PING_INQ    = 5'd14;
  localparam logic [EventW-1:0] EV_PARAM_TO    = 5'd15;
  localparam logic [EventW-1:0] EV_PING_TO     = 5'd16;
  localparam logic [EventW-1:0] EV_PREAMP_ON   = 5'd17;
  localparam logic [EventW-1:0] EV_PREAMP_OFF  = 5'd18;
  localparam logic [EventW-1:0] EV_POWAMP_ON   = 5'd19;
  localparam logic [EventW-1:0] EV_POWAMP_OFF  = 5'd20;
  localparam logic [EventW-1:0] EV_TIMEOUT     = 5'd21;

  // Outcome of one event: whether it was handled, and the state it leaves.
  typedef struct packed {
    logic             handled;
    logic [ModeW-1:0] mode_next;
    logic             run_next;
  } disp_t;

endpackage

`default_nettype wire

// ===== hdl/mps_dispatch.sv =====
// ----------------------------------------------------------------------------
// mps_dispatch: event dispatch through the mode hierarchy
// Offers the event to the current mode, its parent and its grandparent,
// and works out the next mode and run flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_dispatch
  import mps_pkg::*;
(
  input  wire logic [ModeW-1:0]  mode,
  input  wire logic              run_flag,
  input  wire logic              motor_present,
  input  wire logic [EventW-1:0] event_code,
  output disp_t                  disp
);

  typedef struct packed {
    logic             hit;
    logic [ModeW-1:0] dst;
  } hit_t;

  function automatic logic [ModeW-1:0] parent_of(input logic [ModeW-1:0] m);
    logic [ModeW-1:0] p;
    case (m)
      MODE_PREON, MODE_PREOFF, MODE_ARMED:  p = MODE_IDLE;
      MODE_POWON, MODE_POWOFF, MODE_ACTIVE: p = MODE_ARMED;
      default:                              p = MODE_NONE;
    endcase
    return p;
  endfunction

  // Handler of one mode. An event handled without a move keeps the current
  // mode, not the mode of the handler.
  function automatic hit_t handle_in(input logic [ModeW-1:0]  m,
                                     input logic [EventW-1:0] ev,
                                     input logic [ModeW-1:0]  cur,
                                     input logic              present,
                                     input logic              run);
    hit_t r;
    r.hit = 1'b1;
    r.dst = cur;
    case (m)
      MODE_OFF: begin
        if (ev == EV_START) r.dst = present ? MODE_STARTING : MODE_NOMOTOR;
        else                r.hit = 1'b0;
      end
      MODE_NOMOTOR: begin
        if (ev == EV_STOP) r.dst = MODE_OFF;
        else               r.hit = 1'b0;
      end
      MODE_STARTING: begin
        case (ev)
          EV_STOP:       r.dst = MODE_OFF;
          EV_PRESENT:    r.dst = MODE_POWERED;
          EV_BRINGUP_TO: r.dst = cur;
          default:       r.hit = 1'b0;
        endcase
      end
      MODE_POWERED: begin
        case (ev)
          EV_BRINGUP_TO:  r.dst = run ? MODE_POWERED : MODE_OFF;
          EV_STATUS_OK:   r.dst = MODE_IDLE;
          EV_STOP:        r.dst = MODE_OFF;
          EV_NOT_PRESENT: r.dst = run ? MODE_STARTING : MODE_OFF;
          default:        r.hit = 1'b0;
        endcase
      end
      MODE_IDLE: begin
        case (ev) inside
          EV_STOP, EV_NOT_PRESENT, EV_STATUS_EE, EV_STATUS_DE, EV_STATUS_TEMP:
            r.dst = MODE_OFF;
          EV_TEMP_INQ, EV_PARAM_INQ, EV_PING_INQ, EV_PARAM_TO:
            r.dst = cur;
          EV_PREAMP_ON:
            r.dst = MODE_PREON;
          EV_STATUS_ERR, EV_PING_TO:
            r.dst = MODE_POWERED;
          default:
            r.hit = 1'b0;
        endcase
      end
      MODE_PREON: begin
        case (ev) inside
          EV_STATUS_ED:              r.dst = MODE_ARMED;
          EV_PREAMP_OFF, EV_TIMEOUT: r.dst = MODE_IDLE;
          default:                   r.hit = 1'b0;
        endcase
      end
      MODE_PREOFF: begin
        case (ev)
          EV_STATUS_ED: r.dst = cur;
          EV_STATUS_DD: r.dst = MODE_IDLE;
          EV_TIMEOUT:   r.dst = MODE_PREOFF;
          EV_PREAMP_ON: r.dst = MODE_PREON;
          default:      r.hit = 1'b0;
        endcase
      end
      MODE_ARMED: begin
        case (ev)
          EV_STATUS_ED:  r.dst = cur;
          EV_PREAMP_OFF: r.dst = MODE_PREOFF;
          EV_STATUS_DD:  r.dst = MODE_POWERED;
          EV_POWAMP_ON:  r.dst = MODE_POWON;
          default:       r.hit = 1'b0;
        endcase
      end
      MODE_POWON: begin
        case (ev) inside
          EV_STATUS_EE:              r.dst = MODE_ACTIVE;
          EV_POWAMP_OFF, EV_TIMEOUT: r.dst = MODE_ARMED;
          default:                   r.hit = 1'b0;
        endcase
      end
      MODE_POWOFF: begin
        case (ev)
          EV_STATUS_EE: r.dst = cur;
          EV_STATUS_ED: r.dst = MODE_ARMED;
          EV_TIMEOUT:   r.dst = MODE_POWOFF;
          default:      r.hit = 1'b0;
        endcase
      end
      MODE_ACTIVE: begin
        case (ev)
          EV_STATUS_EE:  r.dst = cur;
          EV_POWAMP_OFF: r.dst = MODE_POWOFF;
          EV_STATUS_ED:  r.dst = MODE_POWON;
          default:       r.hit = 1'b0;
        endcase
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  logic [ModeW-1:0] parent_mode;
  logic [ModeW-1:0] grand_mode;
  hit_t             hit_self;
  hit_t             hit_parent;
  hit_t             hit_grand;
  hit_t             chosen;

  assign parent_mode = parent_of(mode);
  assign grand_mode  = parent_of(parent_mode);

  // The three levels are looked up side by side; the nearest one wins.
  assign hit_self   = handle_in(mode, event_code, mode, motor_present, run_flag);
  assign hit_parent = handle_in(parent_mode, event_code, mode, motor_present, run_flag);
  assign hit_grand  = handle_in(grand_mode, event_code, mode, motor_present, run_flag);

  always_comb begin
    if (hit_self.hit)        chosen = hit_self;
    else if (hit_parent.hit) chosen = hit_parent;
    else                     chosen = hit_grand;

    disp.handled   = chosen.hit;
    disp.mode_next = mode;
    disp.run_next  = run_flag;
    if (chosen.hit && (chosen.dst != mode)) begin
      disp.mode_next = chosen.dst;
      if (mode == MODE_OFF)      disp.run_next = 1'b1;
      if (chosen.dst == MODE_OFF) disp.run_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/motor_power_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// motor_power_sequencer_core: hierarchical power-up sequencer, top level
// Registers each event word, dispatches it through the mode hierarchy and
// registers the resulting mode, run flag and handled bit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | event_code
//  out     | output    | out_valid/out_stall | mode_now, running, was_handled
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data (motor_present)
//
//  An accepted word waits in the input register, then goes via the dispatch
//  logic into the result register. One word per cycle is sustained while the
//  output does not stall; the mode register feeds back through the dispatch
//  logic. rst (synchronous) puts the block in off with the run flag clear and
//  motor_present set. A stall on the output holds the result register, and
//  in_stall rises only when the input register is full and cannot move.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_power_sequencer_core
  import mps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [EventW-1:0] event_code,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [ModeW-1:0]  mode_now,
  output      logic              running,
  output      logic              was_handled,
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire logic              cfg_data
);

  logic              motor_present;
  logic [ModeW-1:0]  mode_q;
  logic              run_q;
  logic              s1_valid;
  logic [EventW-1:0] s1_event;
  logic              advance;
  disp_t             disp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_present <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      motor_present <= cfg_data;
    end
  end

  // The word in the input register moves on when the result register is
  // empty or is being emptied in this cycle.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_event <= event_code;
    end
  end

  mps_dispatch u_dispatch (
    .mode          (mode_q),
    .run_flag      (run_q),
    .motor_present (motor_present),
    .event_code    (s1_event),
    .disp          (disp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q    <= MODE_OFF;
      run_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        mode_q <= disp.mode_next;
        run_q  <= disp.run_next;
      end
      if (advance)         out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode_now    <= disp.mode_next;
      running     <= disp.run_next;
      was_handled <= disp.handled;
    end
  end

`ifndef SYNTHESIS
  a_mode_range : assert property (@(posedge clk) disable iff (rst)
    mode_q <= MODE_ACTIVE)
    else $error("mode register holds an undefined mode");

  a_run_tracks_off : assert property (@(posedge clk) disable iff (rst)
    run_q == (mode_q != MODE_OFF))
    else $error("run flag disagrees with the off mode");

  a_unhandled_keeps : assert property (@(posedge clk) disable iff (rst)
    advance && !disp.handled |=> mode_q == $past(mode_q) && run_q == $past(run_q))
    else $error("unhandled word changed the mode or run flag");

  a_result_matches_state : assert property (@(posedge clk) disable iff (rst)
    advance |=> mode_now == mode_q && running == run_q)
    else $error("result word differs from the new state");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for motor_power_sequencer_core
// Sends event words through the mode hierarchy, mostly walks that go deep
// into the power-up sequence plus stray and undefined codes. Each result
// word is checked against a behavioural model of the sequencer, under
// random gaps, output stalls and changes of the motor-present setting.
// ----------------------------------------------------------------------------

import mps_pkg::*;

typedef struct {
  logic [ModeW-1:0] mode;
  logic             run;
  logic             handled;
} mode_result_t;

class mode_scoreboard;
  logic             present;
  logic [ModeW-1:0] mode;
  logic             run;
  mode_result_t     expected_q[$];
  int               errors;

  function new();
    present = 1'b1;
    mode    = MODE_OFF;
    run     = 1'b0;
    errors  = 0;
  endfunction

  // Reaction of a single mode m to an event while the block sits in cur.
  static function bit mode_handles(input logic [ModeW-1:0] m, input logic [ModeW-1:0] cur,
                                   input logic run_now, input logic present_now,
                                   input logic [EventW-1:0] ev,
                                   output logic [ModeW-1:0] dst);
    dst = cur;
    mode_handles = 1'b1;
    case (m)
      MODE_OFF: begin
        if (ev == EV_START) dst = present_now ? MODE_STARTING : MODE_NOMOTOR;
        else mode_handles = 1'b0;
      end
      MODE_NOMOTOR: begin
        if (ev == EV_STOP) dst = MODE_OFF;
        else mode_handles = 1'b0;
      end
      MODE_STARTING: begin
        case (ev)
          EV_STOP:       dst = MODE_OFF;
          EV_PRESENT:    dst = MODE_POWERED;
          EV_BRINGUP_TO: dst = cur;
          default:       mode_handles = 1'b0;
        endcase
      end
      MODE_POWERED: begin
        case (ev)
          EV_BRINGUP_TO:  dst = run_now ? MODE_POWERED : MODE_OFF;
          EV_STATUS_OK:   dst = MODE_IDLE;
          EV_STOP:        dst = MODE_OFF;
          EV_NOT_PRESENT: dst = run_now ? MODE_STARTING : MODE_OFF;
          default:        mode_handles = 1'b0;
        endcase
      end
      MODE_IDLE: begin
        case (ev)
          EV_STOP, EV_NOT_PRESENT, EV_STATUS_EE, EV_STATUS_DE, EV_STATUS_TEMP:
            dst = MODE_OFF;
          EV_TEMP_INQ, EV_PARAM_INQ, EV_PING_INQ, EV_PARAM_TO:
            dst = cur;
          EV_PREAMP_ON:              dst = MODE_PREON;
          EV_STATUS_ERR, EV_PING_TO: dst = MODE_POWERED;
          default:                   mode_handles = 1'b0;
        endcase
      end
      MODE_PREON: begin
        case (ev)
          EV_STATUS_ED:              dst = MODE_ARMED;
          EV_PREAMP_OFF, EV_TIMEOUT: dst = MODE_IDLE;
          default:                   mode_handles = 1'b0;
        endcase
      end
      MODE_PREOFF: begin
        case (ev)
          EV_STATUS_ED: dst = cur;
          EV_STATUS_DD: dst = MODE_IDLE;
          EV_TIMEOUT:   dst = MODE_PREOFF;
          EV_PREAMP_ON: dst = MODE_PREON;
          default:      mode_handles = 1'b0;
        endcase
      end
      MODE_ARMED: begin
        case (ev)
          EV_STATUS_ED:  dst = cur;
          EV_PREAMP_OFF: dst = MODE_PREOFF;
          EV_STATUS_DD:  dst = MODE_POWERED;
          EV_POWAMP_ON:  dst = MODE_POWON;
          default:       mode_handles = 1'b0;
        endcase
      end
      MODE_POWON: begin
        case (ev)
          EV_STATUS_EE:              dst = MODE_ACTIVE;
          EV_POWAMP_OFF, EV_TIMEOUT: dst = MODE_ARMED;
          default:                   mode_handles = 1'b0;
        endcase
      end
      MODE_POWOFF: begin
        case (ev)
          EV_STATUS_EE: dst = cur;
          EV_STATUS_ED: dst = MODE_ARMED;
          EV_TIMEOUT:   dst = MODE_POWOFF;
          default:      mode_handles = 1'b0;
        endcase
      end
      MODE_ACTIVE: begin
        case (ev)
          EV_STATUS_EE:  dst = cur;
          EV_POWAMP_OFF: dst = MODE_POWOFF;
          EV_STATUS_ED:  dst = MODE_POWON;
          default:       mode_handles = 1'b0;
        endcase
      end
      default: mode_handles = 1'b0;
    endcase
  endfunction

  // One event offered to the current mode, then to its parent and grandparent.
  static function void advance(input logic [ModeW-1:0] cur, input logic run_now,
                               input logic present_now, input logic [EventW-1:0] ev,
                               output logic [ModeW-1:0] nxt, output logic run_nxt,
                               output logic handled);
    logic [ModeW-1:0] m;
    logic [ModeW-1:0] dst;
    bit               hit;
    m       = cur;
    dst     = cur;
    nxt     = cur;
    run_nxt = run_now;
    handled = 1'b0;
    for (int lvl = 0; lvl < 3 && m != MODE_NONE && !handled; lvl++) begin
      hit = mode_handles(m, cur, run_now, present_now, ev, dst);
      if (hit) handled = 1'b1;
      else if (m == MODE_PREON || m == MODE_PREOFF || m == MODE_ARMED) m = MODE_IDLE;
      else if (m == MODE_POWON || m == MODE_POWOFF || m == MODE_ACTIVE) m = MODE_ARMED;
      else m = MODE_NONE;
    end
    if (handled && dst != cur) begin
      if (cur == MODE_OFF) run_nxt = 1'b1;
      if (dst == MODE_OFF) run_nxt = 1'b0;
      nxt = dst;
    end
  endfunction

  function void note_event(input logic [EventW-1:0] ev);
    mode_result_t res;
    advance(mode, run, present, ev, res.mode, res.run, res.handled);
    mode = res.mode;
    run  = res.run;
    expected_q.push_back(res);
  endfunction

  function void check_result(input logic [ModeW-1:0] m, input logic r, input logic h);
    mode_result_t exp_res;
    if (expected_q.size() == 0) begin
      $error("result word with no event outstanding: mode_now %0d", m);
      errors++;
      return;
    end
    exp_res = expected_q.pop_front();
    if (m !== exp_res.mode) begin
      $error("mode_now: expected %0d, got %0d", exp_res.mode, m);
      errors++;
    end
    if (r !== exp_res.run) begin
      $error("running: expected %0d, got %0d", exp_res.run, r);
      errors++;
    end
    if (h !== exp_res.handled) begin
      $error("was_handled: expected %0d, got %0d", exp_res.handled, h);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb;
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [EventW-1:0] event_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ModeW-1:0]  mode_now;
  logic              running;
  logic              was_handled;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;

  mode_scoreboard    sb = new();

  // The sender's own view of the mode, used to steer words deep into the
  // sequence. Settings only change while the block is idle, so it tracks.
  logic [ModeW-1:0]  gen_mode = MODE_OFF;
  logic              gen_run = 1'b0;
  logic              gen_present = 1'b1;
  int                hold_cycles = 0;

  motor_power_sequencer_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .event_code  (event_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mode_now    (mode_now),
    .running     (running),
    .was_handled (was_handled),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(mode_now, running, was_handled);
      if (in_valid && !in_stall) sb.note_event(event_code);
      if (cfg_valid && cfg_ready) sb.present = cfg_data;
    end
  end

  // Receiver: segments of free flow, light and heavy stalling, and on request
  // one long hold-off.
  initial begin
    int seg;
    int pct;
    forever begin
      if (hold_cycles > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       pct = 0;
          1:       pct = 25;
          default: pct = 70;
        endcase
        seg = $urandom_range(5, 40);
        repeat (seg) begin
          @(negedge clk);
          out_stall <= ($urandom_range(0, 99) < pct);
          if (hold_cycles > 0) break;
        end
      end
    end
  end

  task automatic send_word(input logic [EventW-1:0] ev);
    logic [ModeW-1:0] m;
    logic             r;
    logic             h;
    @(negedge clk);
    in_valid   <= 1'b1;
    event_code <= ev;
    sb.advance(gen_mode, gen_run, gen_present, ev, m, r, h);
    gen_mode = m;
    gen_run  = r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_present(input logic v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    gen_present = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Most often a move that pushes further up the sequence, then any handled event,
  // and now and then any code at all.
  function automatic logic [EventW-1:0] pick_event();
    logic [EventW-1:0] fwd_q[$];
    logic [EventW-1:0] any_q[$];
    logic [ModeW-1:0]  m;
    logic              r;
    logic              h;
    int                roll;
    for (int e = 0; e <= int'(EV_TIMEOUT); e++) begin
      sb.advance(gen_mode, gen_run, gen_present, EventW'(e), m, r, h);
      if (h) begin
        any_q.push_back(EventW'(e));
        if (m > gen_mode) fwd_q.push_back(EventW'(e));
      end
    end
    roll = $urandom_range(0, 99);
    if (roll < 45 && fwd_q.size() > 0) return fwd_q[$urandom_range(0, fwd_q.size() - 1)];
    if (roll < 80 && any_q.size() > 0) return any_q[$urandom_range(0, any_q.size() - 1)];
    return EventW'($urandom_range(0, 31));
  endfunction

  initial begin
    logic [EventW-1:0] opening[$];
    int                sent;
    int                burst;
    int                gap;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full climb to the power stage and back, self-moves, undefined codes and
    // a stop that falls two levels up to idle.
    opening = '{EV_STOP, EV_START, EV_BRINGUP_TO, EV_PRESENT, EV_NOT_PRESENT, EV_PRESENT,
                EV_STATUS_OK, EV_PARAM_INQ, EV_PREAMP_ON, EV_STATUS_ED, EV_POWAMP_ON,
                EV_STATUS_EE, EV_POWAMP_OFF, EV_TIMEOUT, EV_STATUS_ED, EV_PREAMP_OFF,
                5'd31, EV_PREAMP_ON, EV_STATUS_ED, EV_POWAMP_ON, EV_STOP};
    foreach (opening[i]) send_word(opening[i]);
    write_present(1'b0);
    send_word(EV_START);
    send_word(5'd22);
    send_word(EV_STOP);

    for (int phase = 0; phase < 4; phase++) begin
      write_present(phase != 1);
      sent = 0;
      while (sent < 100) begin
        burst = $urandom_range(1, 20);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        repeat (burst) send_word(pick_event());
        sent += burst;
        pause(gap);
        if (phase == 1 && sent >= 40 && sent < 40 + burst) begin
          // Hold the output long enough for the block to back up its input.
          hold_cycles = 80;
          repeat (30) send_word(pick_event());
          sent += 30;
        end
        if (phase == 2 && sent >= 50 && sent < 50 + burst) wait_idle();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/mps_pkg.sv
hdl/mps_dispatch.sv
hdl/motor_power_sequencer_core.sv
dv/tb.sv
